>>> src/bqwt_pkg.sv
`timescale 1ns / 1ps

package bqwt_pkg;

    localparam int RES_MAX  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int CNT_W    = 3;
    localparam int LINE_OUT_W = 24;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [7:0] {
        M_SKIP     = 8'b0000_0001,
        M_SKIPCOM  = 8'b0000_0010,
        M_BRACE    = 8'b0000_0100,
        M_BRACECOM = 8'b0000_1000,
        M_WORD     = 8'b0001_0000,
        M_ESC      = 8'b0010_0000,
        M_HEX      = 8'b0100_0000,
        M_OCT      = 8'b1000_0000
    } mode_t;

    typedef enum logic {
        RET_BRACE = 1'b0,
        RET_WORD  = 1'b1
    } ret_t;

    typedef enum logic [2:0] {
        K_CHAR    = 3'd0,
        K_END     = 3'd1,
        K_TOKEN   = 3'd2,
        K_EOI     = 3'd3,
        K_MISSING = 3'd4
    } kind_t;

    typedef struct packed {
        mode_t      mode;
        ret_t       ret;
        logic [11:0] value;
        logic [1:0] digits;
    } scan_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] chr;
        kind_t      kind;
    } emit_t;

    typedef struct packed {
        logic [7:0]            chr;
        kind_t                 kind;
        logic                  last;
        logic [LINE_OUT_W-1:0] line;
    } res_t;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    localparam logic [7:0] CTL_BEL = 8'd7;
    localparam logic [7:0] CTL_BS  = 8'd8;
    localparam logic [7:0] CTL_HT  = 8'd9;
    localparam logic [7:0] CTL_LF  = 8'd10;
    localparam logic [7:0] CTL_VT  = 8'd11;
    localparam logic [7:0] CTL_FF  = 8'd12;
    localparam logic [7:0] CTL_CR  = 8'd13;

    localparam logic [5:0] DIGIT_NONE = 6'd20;
    localparam logic [5:0] HEX_LIMIT  = 6'd15;
    localparam logic [5:0] OCT_LIMIT  = 6'd7;
    localparam logic [1:0] HEX_LAST   = 2'd2;
    localparam logic [1:0] OCT_LAST   = 2'd1;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [5:0] digit_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= CH_ZERO && b <= CH_NINE)
            d = b - CH_ZERO;
        else if (b >= CH_UC_A && b <= CH_UC_Z)
            d = b - CH_UC_A + 8'd10;
        else if (b >= CH_LC_A && b <= CH_LC_Z)
            d = b - CH_LC_A + 8'd10;
        else
            d = {2'b00, DIGIT_NONE};
        return d[5:0];
    endfunction

    function automatic mode_t return_mode(input ret_t r);
        return (r == RET_WORD) ? M_WORD : M_BRACE;
    endfunction

endpackage

>>> src/bqwt_pass.sv
`timescale 1ns / 1ps

module bqwt_pass #(
    parameter int NEST_BITS = 16
) (
    input  logic                  active,
    input  bqwt_pkg::scan_t       st_in,
    input  logic [NEST_BITS-1:0]  depth_in,
    input  logic [7:0]            byte_in,
    input  logic                  bat,
    output bqwt_pkg::scan_t       st_out,
    output logic [NEST_BITS-1:0]  depth_out,
    output bqwt_pkg::emit_t       em,
    output logic                  cont,
    output logic                  bump
);

    logic [5:0]  d;
    logic [11:0] hex_val;
    logic [11:0] oct_val;
    logic [1:0]  dig_inc;

    assign d       = bqwt_pkg::digit_value(byte_in);
    assign hex_val = {st_in.value[7:0], d[3:0]};
    assign oct_val = {st_in.value[8:0], d[2:0]};
    assign dig_inc = st_in.digits + 2'd1;

    always_comb
    begin
        st_out    = st_in;
        depth_out = depth_in;
        em        = '0;
        em.kind   = bqwt_pkg::K_CHAR;
        cont      = 1'b0;
        bump      = 1'b0;
        if (active)
        begin
            unique case (st_in.mode)
                bqwt_pkg::M_SKIPCOM:
                begin
                    if (byte_in == bqwt_pkg::CH_NL)
                    begin
                        bump        = 1'b1;
                        st_out.mode = bqwt_pkg::M_SKIP;
                    end
                end
                bqwt_pkg::M_BRACECOM:
                begin
                    if (byte_in == bqwt_pkg::CH_NL)
                    begin
                        bump        = 1'b1;
                        st_out.mode = bqwt_pkg::M_BRACE;
                    end
                end
                bqwt_pkg::M_BRACE:
                begin
                    priority if (byte_in == bqwt_pkg::CH_HASH)
                    begin
                        st_out.mode = bqwt_pkg::M_BRACECOM;
                    end
                    else if (byte_in == bqwt_pkg::CH_BSLASH)
                    begin
                        st_out.ret  = bqwt_pkg::RET_BRACE;
                        st_out.mode = bqwt_pkg::M_ESC;
                    end
                    else if (byte_in == bqwt_pkg::CH_LBRACE)
                    begin
                        if (depth_in != '1)
                            depth_out = depth_in + NEST_BITS'(1);
                        em.valid = 1'b1;
                        em.chr   = byte_in;
                    end
                    else if (byte_in == bqwt_pkg::CH_RBRACE)
                    begin
                        if (depth_in == '0)
                        begin
                            em.valid    = 1'b1;
                            em.kind     = bqwt_pkg::K_END;
                            st_out.mode = bqwt_pkg::M_SKIP;
                        end
                        else
                        begin
                            depth_out = depth_in - NEST_BITS'(1);
                            em.valid  = 1'b1;
                            em.chr    = byte_in;
                        end
                    end
                    else
                    begin
                        bump     = (byte_in == bqwt_pkg::CH_NL);
                        em.valid = 1'b1;
                        em.chr   = byte_in;
                    end
                end
                bqwt_pkg::M_WORD:
                begin
                    priority if (byte_in == bqwt_pkg::CH_BSLASH)
                    begin
                        st_out.ret  = bqwt_pkg::RET_WORD;
                        st_out.mode = bqwt_pkg::M_ESC;
                    end
                    else if (bqwt_pkg::is_space(byte_in) || byte_in == bqwt_pkg::CH_LBRACE ||
                             byte_in == bqwt_pkg::CH_RBRACE || byte_in == bqwt_pkg::CH_HASH)
                    begin
                        em.valid    = 1'b1;
                        em.kind     = bqwt_pkg::K_END;
                        st_out.mode = bqwt_pkg::M_SKIP;
                        cont        = 1'b1;
                    end
                    else
                    begin
                        em.valid = 1'b1;
                        em.chr   = byte_in;
                    end
                end
                bqwt_pkg::M_ESC:
                begin
                    st_out.mode = bqwt_pkg::return_mode(st_in.ret);
                    em.valid    = 1'b1;
                    unique case (byte_in)
                        bqwt_pkg::CH_NL:
                        begin
                            em.valid = 1'b0;
                            bump     = 1'b1;
                        end
                        bqwt_pkg::CH_LC_A: em.chr = bqwt_pkg::CTL_BEL;
                        bqwt_pkg::CH_LC_B: em.chr = bqwt_pkg::CTL_BS;
                        bqwt_pkg::CH_LC_F: em.chr = bqwt_pkg::CTL_FF;
                        bqwt_pkg::CH_LC_N: em.chr = bqwt_pkg::CTL_LF;
                        bqwt_pkg::CH_LC_R: em.chr = bqwt_pkg::CTL_CR;
                        bqwt_pkg::CH_LC_T: em.chr = bqwt_pkg::CTL_HT;
                        bqwt_pkg::CH_LC_V: em.chr = bqwt_pkg::CTL_VT;
                        bqwt_pkg::CH_LC_X:
                        begin
                            em.valid      = 1'b0;
                            st_out.mode   = bqwt_pkg::M_HEX;
                            st_out.value  = '0;
                            st_out.digits = '0;
                        end
                        default:
                        begin
                            if (byte_in >= bqwt_pkg::CH_ZERO && byte_in <= bqwt_pkg::CH_SEVEN)
                            begin
                                em.valid      = 1'b0;
                                st_out.mode   = bqwt_pkg::M_OCT;
                                st_out.value  = {9'd0, byte_in[2:0]};
                                st_out.digits = '0;
                            end
                            else
                            begin
                                em.chr = byte_in;
                            end
                        end
                    endcase
                end
                bqwt_pkg::M_HEX:
                begin
                    if (d > bqwt_pkg::HEX_LIMIT)
                    begin
                        em.valid      = 1'b1;
                        em.chr        = st_in.value[7:0];
                        st_out.mode   = bqwt_pkg::return_mode(st_in.ret);
                        st_out.value  = '0;
                        st_out.digits = '0;
                        cont          = 1'b1;
                    end
                    else if (st_in.digits >= bqwt_pkg::HEX_LAST)
                    begin
                        em.valid      = 1'b1;
                        em.chr        = hex_val[7:0];
                        st_out.mode   = bqwt_pkg::return_mode(st_in.ret);
                        st_out.value  = '0;
                        st_out.digits = '0;
                    end
                    else
                    begin
                        st_out.value  = hex_val;
                        st_out.digits = dig_inc;
                    end
                end
                bqwt_pkg::M_OCT:
                begin
                    if (d > bqwt_pkg::OCT_LIMIT)
                    begin
                        em.valid      = 1'b1;
                        em.chr        = st_in.value[7:0];
                        st_out.mode   = bqwt_pkg::return_mode(st_in.ret);
                        st_out.value  = '0;
                        st_out.digits = '0;
                        cont          = 1'b1;
                    end
                    else if (st_in.digits >= bqwt_pkg::OCT_LAST)
                    begin
                        em.valid      = 1'b1;
                        em.chr        = oct_val[7:0];
                        st_out.mode   = bqwt_pkg::return_mode(st_in.ret);
                        st_out.value  = '0;
                        st_out.digits = '0;
                    end
                    else
                    begin
                        st_out.value  = oct_val;
                        st_out.digits = dig_inc;
                    end
                end
                default:
                begin
                    st_out.mode = bqwt_pkg::M_SKIP;
                    priority if (byte_in == bqwt_pkg::CH_HASH)
                    begin
                        st_out.mode = bqwt_pkg::M_SKIPCOM;
                    end
                    else if (byte_in == bqwt_pkg::CH_NL)
                    begin
                        bump = 1'b1;
                    end
                    else if (bqwt_pkg::is_space(byte_in))
                    begin
                        bump = 1'b0;
                    end
                    else if (byte_in == bqwt_pkg::CH_LBRACE && !bat)
                    begin
                        st_out.mode = bqwt_pkg::M_BRACE;
                        depth_out   = '0;
                    end
                    else if (byte_in == bqwt_pkg::CH_LBRACE || byte_in == bqwt_pkg::CH_RBRACE)
                    begin
                        em.valid = 1'b1;
                        em.chr   = byte_in;
                        em.kind  = bqwt_pkg::K_TOKEN;
                    end
                    else
                    begin
                        st_out.mode = bqwt_pkg::M_WORD;
                        cont        = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

>>> src/bqwt_queue.sv
`timescale 1ns / 1ps

module bqwt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_cnt,
    input  bqwt_pkg::res_t       push_ent [bqwt_pkg::RES_MAX],
    input  logic                 pop,
    output bqwt_pkg::res_t       head,
    output logic                 nonempty,
    output logic                 room
);

    bqwt_pkg::res_t slot_reg  [bqwt_pkg::Q_DEPTH];
    bqwt_pkg::res_t slot_next [bqwt_pkg::Q_DEPTH];
    bqwt_pkg::res_t shifted   [bqwt_pkg::Q_DEPTH];
    bqwt_pkg::cnt_t count_reg;
    bqwt_pkg::cnt_t count_next;
    bqwt_pkg::cnt_t cnt_pop;

    assign head     = slot_reg[0];
    assign nonempty = (count_reg != '0);
    assign room     = (count_reg <= bqwt_pkg::cnt_t'(bqwt_pkg::Q_DEPTH - bqwt_pkg::RES_MAX));
    assign cnt_pop  = count_reg - bqwt_pkg::cnt_t'(pop);

    always_comb
    begin
        bqwt_pkg::cnt_t off;
        off = '0;
        shifted[bqwt_pkg::Q_DEPTH-1] = slot_reg[bqwt_pkg::Q_DEPTH-1];
        for (int i = 0; i < bqwt_pkg::Q_DEPTH - 1; i++)
            shifted[i] = pop ? slot_reg[i+1] : slot_reg[i];
        for (int i = 0; i < bqwt_pkg::Q_DEPTH; i++)
        begin
            slot_next[i] = shifted[i];
            if (bqwt_pkg::cnt_t'(i) >= cnt_pop)
            begin
                off = bqwt_pkg::cnt_t'(i) - cnt_pop;
                if (off < bqwt_pkg::cnt_t'(push_cnt))
                    slot_next[i] = push_ent[off[1:0]];
            end
        end
        count_next = cnt_pop + bqwt_pkg::cnt_t'(push_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bqwt_pkg::Q_DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

endmodule

>>> src/brace_quoted_word_tokenizer_top.sv
`timescale 1ns / 1ps

// channel  | signals                    | payload
// s (in)   | s_tvalid s_tready s_tdata  | tdata: in_byte; tuser: end_of_input, brace_as_token
//          | s_tuser                    |
// m (out)  | m_tvalid m_tready m_tdata  | tdata: out_char, line_number; tuser: out_kind;
//          | m_tuser m_tlast            | tlast: last result of the item
//
// one item a cycle enters the input register while s_tready is high; the scan step writes
// zero to three results into a four-entry result queue, one result leaves a cycle while
// m_tready is high; the step fires only while the queue holds at most one result, so
// multi-result items are paced by the output drain of one result per cycle
// reset empties both stages, scanner goes between words, line count to one
// output stalls back up through the queue to s_tready without losing any item

module brace_quoted_word_tokenizer_top #(
    parameter int NEST_BITS = 16,
    parameter int LINE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [0] end_of_input, [1] brace_as_token
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_char, [31:8] line_number
    output logic [2:0]  m_tuser,   // [2:0] out_kind
    output logic        m_tlast
);

    localparam int RN = bqwt_pkg::RES_MAX;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_eoi_reg;
    logic                  in_bat_reg;

    bqwt_pkg::scan_t       scan_reg;
    bqwt_pkg::scan_t       scan_next;
    logic [NEST_BITS-1:0]  depth_reg;
    logic [NEST_BITS-1:0]  depth_next;
    logic [LINE_BITS-1:0]  line_reg;
    logic [LINE_BITS-1:0]  line_next;

    bqwt_pkg::scan_t       st_chain    [RN+1];
    logic [NEST_BITS-1:0]  depth_chain [RN+1];
    bqwt_pkg::emit_t       em          [RN];
    logic [RN-1:0]         cont;
    logic [RN-1:0]         bump;
    logic [RN-1:0]         act;

    bqwt_pkg::emit_t       fin         [RN];
    logic                  fin_bump;
    bqwt_pkg::emit_t       e           [RN];
    bqwt_pkg::res_t        push_ent    [RN];
    logic [1:0]            n;
    logic                  bump_any;

    logic                  fire;
    logic                  room;
    logic                  pop;
    bqwt_pkg::res_t        head;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser[0];
            in_bat_reg  <= s_tuser[1];
        end
    end

    // scan chain, a pass continues only when the byte is scanned again
    assign st_chain[0]    = scan_reg;
    assign depth_chain[0] = depth_reg;
    assign act[0]         = 1'b1;

    for (genvar g = 1; g < RN; g++)
    begin : g_act
        assign act[g] = cont[g-1];
    end

    for (genvar g = 0; g < RN; g++)
    begin : g_pass
        bqwt_pass #(
            .NEST_BITS (NEST_BITS)
        ) u_pass (
            .active    (act[g]),
            .st_in     (st_chain[g]),
            .depth_in  (depth_chain[g]),
            .byte_in   (in_byte_reg),
            .bat       (in_bat_reg),
            .st_out    (st_chain[g+1]),
            .depth_out (depth_chain[g+1]),
            .em        (em[g]),
            .cont      (cont[g]),
            .bump      (bump[g])
        );
    end

    // end of input: flush pending hex or octal escape, close word or flag unclosed brace, then end marker
    always_comb
    begin
        bqwt_pkg::mode_t m;
        m        = scan_reg.mode;
        fin_bump = 1'b0;
        for (int k = 0; k < RN; k++)
        begin
            fin[k]      = '0;
            fin[k].kind = bqwt_pkg::K_CHAR;
        end
        if (scan_reg.mode == bqwt_pkg::M_ESC)
        begin
            m = bqwt_pkg::return_mode(scan_reg.ret);
        end
        else if (scan_reg.mode == bqwt_pkg::M_HEX || scan_reg.mode == bqwt_pkg::M_OCT)
        begin
            fin[0].valid = 1'b1;
            fin[0].chr   = scan_reg.value[7:0];
            m = bqwt_pkg::return_mode(scan_reg.ret);
        end
        if (m == bqwt_pkg::M_SKIPCOM)
        begin
            fin_bump = 1'b1;
        end
        else if (m == bqwt_pkg::M_WORD)
        begin
            fin[1].valid = 1'b1;
            fin[1].kind  = bqwt_pkg::K_END;
        end
        else if (m == bqwt_pkg::M_BRACECOM || m == bqwt_pkg::M_BRACE)
        begin
            fin_bump     = (m == bqwt_pkg::M_BRACECOM);
            fin[1].valid = 1'b1;
            fin[1].kind  = bqwt_pkg::K_MISSING;
        end
        fin[2].valid = 1'b1;
        fin[2].kind  = bqwt_pkg::K_EOI;
    end

    always_comb
    begin
        for (int k = 0; k < RN; k++)
            e[k] = in_eoi_reg ? fin[k] : em[k];
        bump_any = in_eoi_reg ? fin_bump : (|bump);
        line_next = (bump_any && line_reg != '1) ? line_reg + LINE_BITS'(1) : line_reg;
        if (in_eoi_reg)
        begin
            scan_next        = '0;
            scan_next.mode   = bqwt_pkg::M_SKIP;
            scan_next.ret    = bqwt_pkg::RET_BRACE;
            depth_next       = '0;
        end
        else
        begin
            scan_next  = st_chain[RN];
            depth_next = depth_chain[RN];
        end
    end

    // pack results to the front in order
    always_comb
    begin
        bqwt_pkg::emit_t c [RN];
        c[0] = e[0].valid ? e[0] : (e[1].valid ? e[1] : e[2]);
        c[1] = e[0].valid ? (e[1].valid ? e[1] : e[2]) : e[2];
        c[2] = e[2];
        n = {1'b0, e[0].valid} + {1'b0, e[1].valid} + {1'b0, e[2].valid};
        for (int k = 0; k < RN; k++)
        begin
            push_ent[k].chr  = c[k].chr;
            push_ent[k].kind = c[k].kind;
            push_ent[k].last = (2'(k) == n - 2'd1);
            push_ent[k].line = bqwt_pkg::LINE_OUT_W'(line_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg.mode   <= bqwt_pkg::M_SKIP;
            scan_reg.ret    <= bqwt_pkg::RET_BRACE;
            scan_reg.value  <= '0;
            scan_reg.digits <= '0;
            depth_reg       <= '0;
            line_reg        <= LINE_BITS'(1);
        end
        else if (fire)
        begin
            scan_reg  <= scan_next;
            depth_reg <= depth_next;
            line_reg  <= line_next;
        end
    end

    bqwt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (fire ? n : 2'd0),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .nonempty (m_tvalid),
        .room     (room)
    );

    assign m_tdata = {head.line, head.chr};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
